FILE: rtl/fjh_pkg.sv
// shared types, field widths and codes for the forward jump hop counter
package fjh_pkg;

	// payload field widths
	localparam int FUNC_W  = 1;
	localparam int POS_W   = 10;
	localparam int JUMP_W  = 11;
	localparam int COUNT_W = 11;
	localparam int USED_W  = 11;

	// parameter defaults
	localparam int MAX_POSITIONS_DEF = 1024;
	localparam int BLOCK_SIZE_DEF    = 32;

	// used_positions after reset
	localparam int USED_RST = 1024;

	// operation codes on func
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b1;

	// write strobes from the sequencer to the table memories
	typedef struct packed {
		logic jump_we;
		logic skip_we;
	} tbl_ctl_t;

endpackage

FILE: rtl/fjh_tables.sv
// jump distance memory and skip memory (exit position and hop count), both with registered reads
module fjh_tables #(
	parameter int MAX_POSITIONS = fjh_pkg::MAX_POSITIONS_DEF,
	parameter int BLOCK_SIZE    = fjh_pkg::BLOCK_SIZE_DEF,
	localparam int AW = $clog2(MAX_POSITIONS),
	localparam int NW = $clog2(MAX_POSITIONS + 1),
	localparam int HW = $clog2(BLOCK_SIZE + 1)
) (
	input  logic                      clk,
	input  fjh_pkg::tbl_ctl_t         ctl,
	input  logic [AW-1:0]             jump_waddr,
	input  logic [fjh_pkg::JUMP_W-1:0] jump_wdata,
	input  logic [AW-1:0]             jump_raddr,
	output logic [fjh_pkg::JUMP_W-1:0] jump_rdata,
	input  logic [AW-1:0]             skip_waddr,
	input  logic [NW-1:0]             skip_wexit,
	input  logic [HW-1:0]             skip_whops,
	input  logic [AW-1:0]             skip_raddr,
	output logic [NW-1:0]             skip_rexit,
	output logic [HW-1:0]             skip_rhops
);
	import fjh_pkg::*;

	logic [JUMP_W-1:0]  jump_mem [MAX_POSITIONS];
	logic [NW+HW-1:0]   skip_mem [MAX_POSITIONS];
	logic [NW+HW-1:0]   skip_rd_q;

	// read returns the old word when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (ctl.jump_we) begin
			jump_mem[jump_waddr] <= jump_wdata;
		end
		jump_rdata <= jump_mem[jump_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.skip_we) begin
			skip_mem[skip_waddr] <= {skip_wexit, skip_whops};
		end
		skip_rd_q <= skip_mem[skip_raddr];
	end

	assign skip_rexit = skip_rd_q[NW+HW-1:HW];
	assign skip_rhops = skip_rd_q[HW-1:0];

endmodule

FILE: rtl/fjh_seq.sv
// sequencer: clearing pass, block rebuild pipeline, query walk
module fjh_seq #(
	parameter int MAX_POSITIONS = fjh_pkg::MAX_POSITIONS_DEF,
	parameter int BLOCK_SIZE    = fjh_pkg::BLOCK_SIZE_DEF,
	localparam int AW = $clog2(MAX_POSITIONS),
	localparam int NW = $clog2(MAX_POSITIONS + 1),
	localparam int HW = $clog2(BLOCK_SIZE + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [NW-1:0]              n,
	input  logic                       cfg_we,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fjh_pkg::FUNC_W-1:0]  in_func,
	input  logic [fjh_pkg::POS_W-1:0]   in_pos,
	input  logic [fjh_pkg::JUMP_W-1:0]  in_jump,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [fjh_pkg::COUNT_W-1:0] res_count,
	output fjh_pkg::tbl_ctl_t          ctl,
	output logic [AW-1:0]              jump_waddr,
	output logic [fjh_pkg::JUMP_W-1:0]  jump_wdata,
	output logic [AW-1:0]              jump_raddr,
	input  logic [fjh_pkg::JUMP_W-1:0]  jump_rdata,
	output logic [AW-1:0]              skip_waddr,
	output logic [NW-1:0]              skip_wexit,
	output logic [HW-1:0]              skip_whops,
	output logic [AW-1:0]              skip_raddr,
	input  logic [NW-1:0]              skip_rexit,
	input  logic [HW-1:0]              skip_rhops
);
	import fjh_pkg::*;

	localparam int TW    = ((NW > JUMP_W) ? NW : JUMP_W) + 1;
	// block index by reciprocal multiply, exact for every address below 2**AW
	localparam int SH    = AW + $clog2(BLOCK_SIZE);
	localparam int RECIP = (2 ** SH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int RW    = $clog2(RECIP + 1);
	localparam int PW    = AW + RW;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_DIV,
		ST_SETUP,
		ST_REBUILD,
		ST_WALK,
		ST_RESULT
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic                restart_q;
	logic                rb_all_q;
	logic                iss_q;
	logic                valid_s1;
	logic                valid_s2;
	logic                fwd_vld_q;

	logic [NW-1:0]       nw_q;
	logic [FUNC_W-1:0]   func_q;
	logic [POS_W-1:0]    pos_q;
	logic [JUMP_W-1:0]   nj_q;
	logic [PW-1:0]       prod_q;
	logic [AW-1:0]       blk_start_q;
	logic [AW-1:0]       blk_end_q;
	logic [AW-1:0]       rd_i_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [AW-1:0]       i_s1;
	logic [AW-1:0]       i_s2;
	logic [TW-1:0]       t_s2;
	logic                ext_s2;
	logic [AW-1:0]       fwd_addr_q;
	logic [NW-1:0]       fwd_exit_q;
	logic [HW-1:0]       fwd_hops_q;

	logic                accept;
	logic                pos_ok;
	logic                pos_used;
	logic [TW-1:0]       t_s1;
	logic                fwd_hit;
	logic [NW-1:0]       src_exit;
	logic [HW-1:0]       src_hops;
	logic                walk_end;
	logic [TW-1:0]       blk_last;
	logic [TW-1:0]       used_last;
	logic [TW-1:0]       next_start;
	logic                rb_done;

	assign accept     = in_valid && in_ready;
	assign pos_ok     = TW'(pos_q) < TW'(MAX_POSITIONS);
	assign pos_used   = TW'(pos_q) < TW'(nw_q);
	assign t_s1       = TW'(i_s1) + TW'(jump_rdata);
	assign walk_end   = TW'(skip_rexit) >= TW'(nw_q);
	assign blk_last   = TW'(blk_start_q) + TW'(BLOCK_SIZE - 1);
	assign used_last  = TW'(nw_q) - TW'(1);
	assign next_start = TW'(blk_start_q) + TW'(BLOCK_SIZE);
	assign rb_done    = !iss_q && !valid_s1 && !valid_s2;

	// the entry written in the previous cycle was not yet visible to the read
	assign fwd_hit  = fwd_vld_q && (TW'(fwd_addr_q) == t_s2);
	assign src_exit = fwd_hit ? fwd_exit_q : skip_rexit;
	assign src_hops = fwd_hit ? fwd_hops_q : skip_rhops;

	always_comb begin
		if (ext_s2) begin
			skip_wexit = (t_s2 > TW'(nw_q)) ? nw_q : NW'(t_s2);
			skip_whops = HW'(1);
		end else begin
			skip_wexit = src_exit;
			skip_whops = src_hops + HW'(1);
		end
	end

	assign skip_waddr  = i_s2;
	assign ctl.skip_we = valid_s2;
	assign ctl.jump_we = (state_q == ST_CLEAR) ||
		(state_q == ST_DISPATCH && func_q == FUNC_UPDATE && pos_ok);
	assign jump_waddr  = (state_q == ST_CLEAR) ? clr_q : AW'(pos_q);
	assign jump_wdata  = (state_q == ST_CLEAR || nj_q == '0) ? JUMP_W'(1) : nj_q;
	assign jump_raddr  = rd_i_q;

	always_comb begin
		unique case (state_q)
			ST_DISPATCH: skip_raddr = AW'(pos_q);
			ST_WALK:     skip_raddr = AW'(skip_rexit);
			default:     skip_raddr = AW'(t_s1);
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE) && !restart_q && !cfg_we;
	assign res_valid = (state_q == ST_RESULT);
	assign res_count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			restart_q <= 1'b1;
			rb_all_q  <= 1'b0;
			iss_q     <= 1'b0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			valid_s1  <= (state_q == ST_REBUILD) && iss_q;
			valid_s2  <= valid_s1;
			fwd_vld_q <= valid_s2;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_POSITIONS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (restart_q) begin
						rb_all_q  <= 1'b1;
						state_q   <= ST_SETUP;
					end else if (accept) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (func_q == FUNC_UPDATE) begin
						rb_all_q <= 1'b0;
						state_q  <= (pos_ok && pos_used) ? ST_DIV : ST_IDLE;
					end else begin
						state_q <= pos_used ? ST_WALK : ST_RESULT;
					end
				end
				ST_DIV: begin
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					iss_q   <= 1'b1;
					state_q <= ST_REBUILD;
				end
				ST_REBUILD: begin
					if (iss_q && rd_i_q == blk_start_q) begin
						iss_q <= 1'b0;
					end
					if (rb_done) begin
						state_q <= (rb_all_q && next_start < TW'(nw_q)) ? ST_SETUP : ST_IDLE;
					end
				end
				ST_WALK: begin
					if (walk_end) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				restart_q <= 1'b1;
			end else if (state_q == ST_IDLE && restart_q) begin
				restart_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_s1       <= rd_i_q;
		i_s2       <= i_s1;
		t_s2       <= t_s1;
		ext_s2     <= t_s1 > TW'(blk_end_q);
		fwd_addr_q <= skip_waddr;
		fwd_exit_q <= skip_wexit;
		fwd_hops_q <= skip_whops;
		if (state_q == ST_IDLE) begin
			nw_q <= n;
			if (restart_q) begin
				blk_start_q <= '0;
			end else if (accept) begin
				func_q <= in_func;
				pos_q  <= in_pos;
				nj_q   <= in_jump;
			end
		end
		if (state_q == ST_DISPATCH) begin
			prod_q <= PW'(AW'(pos_q)) * PW'(RECIP);
			cnt_q  <= '0;
		end
		if (state_q == ST_DIV) begin
			blk_start_q <= AW'(32'(prod_q >> SH) * 32'(BLOCK_SIZE));
		end
		if (state_q == ST_SETUP) begin
			blk_end_q <= (blk_last > used_last) ? AW'(used_last) : AW'(blk_last);
			rd_i_q    <= (blk_last > used_last) ? AW'(used_last) : AW'(blk_last);
		end
		if (state_q == ST_REBUILD) begin
			if (iss_q && rd_i_q != blk_start_q) begin
				rd_i_q <= rd_i_q - AW'(1);
			end
			if (rb_done && rb_all_q) begin
				blk_start_q <= AW'(next_start);
			end
		end
		if (state_q == ST_WALK) begin
			cnt_q <= cnt_q + COUNT_W'(skip_rhops);
		end
	end

	// an in-block target lies strictly ahead of the entry being rebuilt
	a_fwd_target: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ext_s2 |-> t_s2 > TW'(i_s2))
		else $error("in-block jump target not ahead of its entry");

	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> i_s2 >= blk_start_q && i_s2 <= blk_end_q)
		else $error("skip write outside the block being rebuilt");

	a_exit_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> TW'(skip_wexit) > TW'(i_s2))
		else $error("skip exit does not move forward");

	a_result_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !iss_q && !valid_s1 && !valid_s2)
		else $error("result offered while a rebuild is in flight");

endmodule

FILE: rtl/forward_jump_hop_counter.sv
// top level: used_positions register, output register, sequencer and table memories
//
//   channel   direction  handshake            payload
//   in        in         in_valid/in_ready    func, position, new_jump
//   out       out        out_valid/out_ready  hop_count
//   cfg       in         cfg_we               cfg_data (used_positions)
//
// query: walks the skip memory one hop per cycle, at most one hop per block
//   of BLOCK_SIZE below used_positions; a start at or past the end makes no hop
// update: writes the jump memory; a position below used_positions also has its block
//   rebuilt, one entry per cycle by the rebuild pipeline on the skip memory
// reset: a clearing pass over the MAX_POSITIONS entries of the jump memory, then a full
//   rebuild of every block below used_positions; no input is taken meanwhile
// a cfg write triggers the same full rebuild; a waiting result stalls input only
//   once the output register is also full
module forward_jump_hop_counter #(
	parameter int MAX_POSITIONS = fjh_pkg::MAX_POSITIONS_DEF,
	parameter int BLOCK_SIZE    = fjh_pkg::BLOCK_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fjh_pkg::USED_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fjh_pkg::FUNC_W-1:0]  func,
	input  logic [fjh_pkg::POS_W-1:0]   position,
	input  logic [fjh_pkg::JUMP_W-1:0]  new_jump,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fjh_pkg::COUNT_W-1:0] hop_count
);
	import fjh_pkg::*;

	localparam int AW    = $clog2(MAX_POSITIONS);
	localparam int NW    = $clog2(MAX_POSITIONS + 1);
	localparam int HW    = $clog2(BLOCK_SIZE + 1);
	localparam int N_RST = (USED_RST > MAX_POSITIONS) ? MAX_POSITIONS : USED_RST;

	logic [NW-1:0]      used_q;
	logic               res_valid;
	logic               res_ready;
	logic [COUNT_W-1:0] res_count;
	logic               out_valid_q;
	logic [COUNT_W-1:0] hop_count_q;
	tbl_ctl_t           ctl;
	logic [AW-1:0]      jump_waddr;
	logic [JUMP_W-1:0]  jump_wdata;
	logic [AW-1:0]      jump_raddr;
	logic [JUMP_W-1:0]  jump_rdata;
	logic [AW-1:0]      skip_waddr;
	logic [NW-1:0]      skip_wexit;
	logic [HW-1:0]      skip_whops;
	logic [AW-1:0]      skip_raddr;
	logic [NW-1:0]      skip_rexit;
	logic [HW-1:0]      skip_rhops;

	// out-of-range counts clamp to 1 and MAX_POSITIONS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= NW'(N_RST);
		end else if (cfg_we) begin
			priority if (cfg_data == '0) begin
				used_q <= NW'(1);
			end else if (32'(cfg_data) > 32'(MAX_POSITIONS)) begin
				used_q <= NW'(MAX_POSITIONS);
			end else begin
				used_q <= NW'(cfg_data);
			end
		end
	end

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			hop_count_q <= res_count;
		end
	end

	assign out_valid = out_valid_q;
	assign hop_count = hop_count_q;

	fjh_seq #(
		.MAX_POSITIONS(MAX_POSITIONS),
		.BLOCK_SIZE   (BLOCK_SIZE)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (used_q),
		.cfg_we    (cfg_we),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_func   (func),
		.in_pos    (position),
		.in_jump   (new_jump),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_count (res_count),
		.ctl       (ctl),
		.jump_waddr(jump_waddr),
		.jump_wdata(jump_wdata),
		.jump_raddr(jump_raddr),
		.jump_rdata(jump_rdata),
		.skip_waddr(skip_waddr),
		.skip_wexit(skip_wexit),
		.skip_whops(skip_whops),
		.skip_raddr(skip_raddr),
		.skip_rexit(skip_rexit),
		.skip_rhops(skip_rhops)
	);

	fjh_tables #(
		.MAX_POSITIONS(MAX_POSITIONS),
		.BLOCK_SIZE   (BLOCK_SIZE)
	) u_tables (
		.clk       (clk),
		.ctl       (ctl),
		.jump_waddr(jump_waddr),
		.jump_wdata(jump_wdata),
		.jump_raddr(jump_raddr),
		.jump_rdata(jump_rdata),
		.skip_waddr(skip_waddr),
		.skip_wexit(skip_wexit),
		.skip_whops(skip_whops),
		.skip_raddr(skip_raddr),
		.skip_rexit(skip_rexit),
		.skip_rhops(skip_rhops)
	);

endmodule

FILE: test/testbench.sv
// testbench for forward_jump_hop_counter: directed and random transfers checked against a jump-walk predictor
`timescale 1ns / 100ps

module testbench;
	import fjh_pkg::*;

	localparam int MAX_POS = MAX_POSITIONS_DEF;

	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [POS_W-1:0]  pos;
		logic [JUMP_W-1:0] jmp;
	} hop_req_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [USED_W-1:0]  cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [FUNC_W-1:0]  func = FUNC_QUERY;
	logic [POS_W-1:0]   position = '0;
	logic [JUMP_W-1:0]  new_jump = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COUNT_W-1:0] hop_count;

	// predictor state
	logic [JUMP_W-1:0]  jump_dist [MAX_POS];
	int                 used_pos = USED_RST;

	hop_req_t           pending_reqs[$];
	logic [COUNT_W-1:0] hop_counts_due[$];
	hop_req_t           cur_req;
	bit                 in_taken = 1'b0;
	bit                 steady = 1'b0;
	bit                 hold_rx = 1'b0;
	int                 n_taken = 0;
	int                 n_bad = 0;

	forward_jump_hop_counter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.position  (position),
		.new_jump  (new_jump),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hop_count (hop_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// sender: present the next request once the previous transfer is done
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
				cur_req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				func     <= cur_req.op;
				position <= cur_req.pos;
				new_jump <= cur_req.jmp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// predictor: walk the chain jump by jump at each input transfer
	always @(posedge clk) begin : accept_side
		int x;
		int hops;
		if (arst_n && in_valid && in_ready) begin
			if (cur_req.op == FUNC_QUERY) begin
				x = int'(cur_req.pos);
				hops = 0;
				while (x < used_pos) begin
					hops++;
					x += int'(jump_dist[x]);
				end
				hop_counts_due.push_back(hops[COUNT_W-1:0]);
			end else begin
				// a zero distance saturates to one
				jump_dist[cur_req.pos] = (cur_req.jmp == '0) ? JUMP_W'(1) : cur_req.jmp;
			end
			in_taken = 1'b1;
			n_taken++;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !hold_rx && (steady || $urandom_range(99) >= 9);
	end

	always @(posedge clk) begin : check_side
		logic [COUNT_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (hop_counts_due.size() == 0) begin
				if (n_bad < 10)
					$display("%0t: unexpected result hop_count=%0d", $realtime, hop_count);
				n_bad++;
			end else begin
				want = hop_counts_due.pop_front();
				if (hop_count !== want) begin
					if (n_bad < 10)
						$display("%0t: hop_count mismatch: expected %0d, got %0d",
							$realtime, want, hop_count);
					n_bad++;
				end
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		while (n_taken < 200)
			@(posedge clk);
		hold_rx = 1'b1;
		repeat (500) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic push_req(input logic [FUNC_W-1:0] op, input int pos, input int jmp);
		hop_req_t r;
		r.op = op;
		r.pos = POS_W'(pos);
		r.jmp = JUMP_W'(jmp);
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (hop_counts_due.size() != 0)
			@(posedge clk);
	endtask

	// register write while idle, once any update has finished rebuilding its block
	task automatic set_used(input int v);
		wait_drained();
		repeat (80) @(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= USED_W'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		v = v & 'h7FF;
		used_pos = (v < 1) ? 1 : (v > MAX_POS) ? MAX_POS : v;
	endtask

	initial begin
		int used_sweep[10] = '{1024, 1, 2, 33, 1025, 32, 100, 2047, 511, 64};
		int r;
		int p;
		int j;
		for (int i = 0; i < MAX_POS; i++)
			jump_dist[i] = JUMP_W'(1);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset state: full chain of unit jumps
		push_req(FUNC_QUERY, 0, 0);
		push_req(FUNC_QUERY, 1023, 0);
		push_req(FUNC_UPDATE, 0, 0);
		push_req(FUNC_QUERY, 0, 2047);
		push_req(FUNC_UPDATE, 1023, 2047);
		push_req(FUNC_QUERY, 1023, 0);
		push_req(FUNC_UPDATE, 31, 1024);
		push_req(FUNC_QUERY, 0, 0);
		push_req(FUNC_UPDATE, 31, 1);

		// short range: queries past the end, update beyond the end
		set_used(40);
		push_req(FUNC_QUERY, 40, 0);
		push_req(FUNC_QUERY, 1023, 0);
		push_req(FUNC_UPDATE, 45, 3);
		push_req(FUNC_QUERY, 39, 0);
		push_req(FUNC_QUERY, 0, 0);

		// oversized write clamps; the stored distance at 45 now counts
		set_used(2047);
		push_req(FUNC_QUERY, 42, 0);
		push_req(FUNC_UPDATE, 45, 1);

		// zero write acts as one position
		set_used(0);
		push_req(FUNC_QUERY, 0, 0);
		push_req(FUNC_QUERY, 1, 0);
		push_req(FUNC_UPDATE, 0, 5);
		push_req(FUNC_QUERY, 0, 0);

		foreach (used_sweep[k]) begin
			set_used(used_sweep[k]);
			steady = (k == 4);
			repeat (135) begin
				r = $urandom_range(99);
				p = ($urandom_range(99) < 88) ? $urandom_range(used_pos - 1)
					: $urandom_range(MAX_POS - 1);
				if (r < 40) begin
					r = $urandom_range(99);
					// mostly short hops so chains cross many blocks
					if (r < 60)
						j = $urandom_range(3, 1);
					else if (r < 85)
						j = $urandom_range(40, 1);
					else if (r < 95)
						j = $urandom_range(2047);
					else
						j = 0;
					push_req(FUNC_UPDATE, p, j);
				end else begin
					push_req(FUNC_QUERY, p, $urandom_range(2047));
				end
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (100) @(posedge clk);
		if (n_bad == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: forward_jump_hop_counter.f
rtl/fjh_pkg.sv
rtl/fjh_tables.sv
rtl/fjh_seq.sv
rtl/forward_jump_hop_counter.sv
test/testbench.sv
